// ----- sv/sskm_pkg.sv -----
// shared constants for the soft spherical shell mask
// register indexes, region codes, fixed widths; no dependencies
package sskm_pkg;

  localparam int COS_TABLE_DEPTH = 256;

  localparam int COORD_W  = 8;
  localparam int DIST_W   = 16;
  localparam int RAD_W    = 16;
  localparam int WEIGHT_W = 16;
  localparam int REGION_W = 3;
  localparam int REM_W    = 2 * DIST_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE  = 2'd2;

  localparam logic [RAD_W-1:0] EDGE_RESET = 16'd256;

  localparam logic [REGION_W-1:0] RGN_HOLE    = 3'd0;
  localparam logic [REGION_W-1:0] RGN_INNER   = 3'd1;
  localparam logic [REGION_W-1:0] RGN_BODY    = 3'd2;
  localparam logic [REGION_W-1:0] RGN_OUTER   = 3'd3;
  localparam logic [REGION_W-1:0] RGN_OUTSIDE = 3'd4;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 16'd32768;
  localparam logic [WEIGHT_W-1:0] WEIGHT_HALF = 16'd16384;

endpackage

// ----- sv/soft_shell_mask_voxel_top.sv -----
// soft spherical shell mask, top level
// uses sskm_pkg, sskm_sqrt_cell, sskm_div_cell, sskm_cos_rom
//
// One voxel beat in, one weight beat out, one voxel per clock sustained unless
// the output stalls. The path runs through the squares register, the root chain
// (one cell per root bit), the region register, the phase divider chain (one
// cell per quotient bit), the cosine table read and the weight register. Every
// stage holds its own valid bit, so bubbles close up and, until every stage is
// full, the input keeps accepting beats while a finished result waits at the
// output. Write the radius and edge registers only while no voxel is in flight.
module soft_shell_mask_voxel_top #(
  parameter int COS_TABLE_DEPTH = sskm_pkg::COS_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // coord_x, coord_y, coord_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // mask_weight
  output logic [2:0]  m_tuser,   // region
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [sskm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int DW = sskm_pkg::DIST_W;
  localparam int RW = sskm_pkg::REM_W;
  localparam int GW = sskm_pkg::REGION_W;
  localparam int QW = $clog2(COS_TABLE_DEPTH + 1);
  localparam int NW = sskm_pkg::RAD_W + QW;

  // configuration
  logic [15:0] inner_radius_vox, outer_radius_vox, edge_width_vox;
  logic [15:0] ew;

  assign cfg_ready = 1'b1;
  assign ew = (edge_width_vox == '0) ? 16'd1 : edge_width_vox;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_radius_vox <= '0;
      outer_radius_vox <= '0;
      edge_width_vox   <= sskm_pkg::EDGE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sskm_pkg::REG_INNER: inner_radius_vox <= cfg_data;
        sskm_pkg::REG_OUTER: outer_radius_vox <= cfg_data;
        sskm_pkg::REG_EDGE:  edge_width_vox   <= cfg_data;
        default: ;
      endcase
    end
  end

  // squares
  logic signed [7:0] cx, cy, cz;
  logic [15:0] sq_sum;
  logic        sq_vld, sq_rdy;

  assign cx = s_tdata[7:0];
  assign cy = s_tdata[15:8];
  assign cz = s_tdata[23:16];
  assign s_tready = !sq_vld || sq_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= 1'b0;
    end else if (s_tready) begin
      sq_vld <= s_tvalid;
    end
    if (s_tready) begin
      // widen before squaring, the sum of three squares fits 16 bits
      sq_sum <= 16'(cx) * 16'(cx) + 16'(cy) * 16'(cy) + 16'(cz) * 16'(cz);
    end
  end

  // root chain, most significant bit first
  logic          rt_vld  [DW+1];
  logic          rt_rdy  [DW+1];
  logic [RW-1:0] rt_rem  [DW+1];
  logic [DW-1:0] rt_root [DW+1];

  assign rt_vld[0]  = sq_vld;
  assign sq_rdy     = rt_rdy[0];
  assign rt_rem[0]  = {sq_sum, 16'd0};
  assign rt_root[0] = '0;

  for (genvar i = 0; i < DW; i++) begin : g_sqrt
    sskm_sqrt_cell #(.BIT(DW - 1 - i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .in_vld  (rt_vld[i]),
      .in_rdy  (rt_rdy[i]),
      .in_rem  (rt_rem[i]),
      .in_root (rt_root[i]),
      .out_vld (rt_vld[i+1]),
      .out_rdy (rt_rdy[i+1]),
      .out_rem (rt_rem[i+1]),
      .out_root(rt_root[i+1])
    );
  end

  // region and edge offset
  logic [DW-1:0] d;
  logic signed [17:0] hole_th;
  logic [16:0]   out_th;
  logic [GW-1:0] region_next;
  logic [15:0]   delta_next;
  logic          rg_vld, rg_rdy;
  logic [GW-1:0] rg_region;
  logic [15:0]   rg_delta;

  assign d       = rt_root[DW];
  assign hole_th = $signed({2'b00, inner_radius_vox}) - $signed({2'b00, ew});
  assign out_th  = {1'b0, outer_radius_vox} + {1'b0, ew};

  always_comb begin
    delta_next = '0;
    if ($signed({2'b00, d}) < hole_th) begin
      region_next = sskm_pkg::RGN_HOLE;
    end else if (d < inner_radius_vox) begin
      region_next = sskm_pkg::RGN_INNER;
      delta_next  = inner_radius_vox - d;
    end else if (d < outer_radius_vox) begin
      region_next = sskm_pkg::RGN_BODY;
    end else if ({1'b0, d} < out_th) begin
      region_next = sskm_pkg::RGN_OUTER;
      delta_next  = d - outer_radius_vox;
    end else begin
      region_next = sskm_pkg::RGN_OUTSIDE;
    end
  end

  assign rt_rdy[DW] = !rg_vld || rg_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      rg_vld <= 1'b0;
    end else if (rt_rdy[DW]) begin
      rg_vld <= rt_vld[DW];
    end
    if (rt_rdy[DW]) begin
      rg_region <= region_next;
      rg_delta  <= delta_next;
    end
  end

  // phase divider chain
  logic          dv_vld [QW+1];
  logic          dv_rdy [QW+1];
  logic [NW-1:0] dv_rem [QW+1];
  logic [QW-1:0] dv_quo [QW+1];
  logic [GW-1:0] dv_rgn [QW+1];

  assign dv_vld[0] = rg_vld;
  assign rg_rdy    = dv_rdy[0];
  assign dv_rem[0] = NW'(rg_delta) * NW'(COS_TABLE_DEPTH);
  assign dv_quo[0] = '0;
  assign dv_rgn[0] = rg_region;

  for (genvar j = 0; j < QW; j++) begin : g_div
    sskm_div_cell #(.NW(NW), .QW(QW), .BIT(QW - 1 - j)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .edge_w    (ew),
      .in_vld    (dv_vld[j]),
      .in_rdy    (dv_rdy[j]),
      .in_rem    (dv_rem[j]),
      .in_quo    (dv_quo[j]),
      .in_region (dv_rgn[j]),
      .out_vld   (dv_vld[j+1]),
      .out_rdy   (dv_rdy[j+1]),
      .out_rem   (dv_rem[j+1]),
      .out_quo   (dv_quo[j+1]),
      .out_region(dv_rgn[j+1])
    );
  end

  sskm_cos_rom #(.DEPTH(COS_TABLE_DEPTH), .QW(QW)) u_cos (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (dv_vld[QW]),
    .in_rdy    (dv_rdy[QW]),
    .in_phase  (dv_quo[QW]),
    .in_region (dv_rgn[QW]),
    .out_vld   (m_tvalid),
    .out_rdy   (m_tready),
    .out_weight(m_tdata),
    .out_region(m_tuser)
  );

endmodule

// ----- sv/sskm_sqrt_cell.sv -----
// one cell of the square-root chain: settles one bit of the root
// uses sskm_pkg for widths
module sskm_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_vld,
  output logic                          in_rdy,
  input  logic [sskm_pkg::REM_W-1:0]    in_rem,
  input  logic [sskm_pkg::DIST_W-1:0]   in_root,
  output logic                          out_vld,
  input  logic                          out_rdy,
  output logic [sskm_pkg::REM_W-1:0]    out_rem,
  output logic [sskm_pkg::DIST_W-1:0]   out_root
);

  localparam int TW = sskm_pkg::REM_W + 2;

  logic [TW-1:0] trial;
  logic          take;

  // (root + 2^b)^2 - root^2
  assign trial = (TW'(in_root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
  assign take  = TW'(in_rem) >= trial;
  assign in_rdy = !out_vld || out_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (in_rdy) begin
      out_vld <= in_vld;
    end
    if (in_rdy) begin
      out_rem  <= take ? sskm_pkg::REM_W'(TW'(in_rem) - trial) : in_rem;
      out_root <= take ? (in_root | (sskm_pkg::DIST_W'(1) << BIT)) : in_root;
    end
  end

endmodule

// ----- sv/sskm_div_cell.sv -----
// one cell of the edge-phase divider chain: settles one quotient bit
// uses sskm_pkg for widths and region codes
module sskm_div_cell #(
  parameter int NW  = 29,
  parameter int QW  = 9,
  parameter int BIT = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [sskm_pkg::RAD_W-1:0]     edge_w,
  input  logic                           in_vld,
  output logic                           in_rdy,
  input  logic [NW-1:0]                  in_rem,
  input  logic [QW-1:0]                  in_quo,
  input  logic [sskm_pkg::REGION_W-1:0]  in_region,
  output logic                           out_vld,
  input  logic                           out_rdy,
  output logic [NW-1:0]                  out_rem,
  output logic [QW-1:0]                  out_quo,
  output logic [sskm_pkg::REGION_W-1:0]  out_region
);

  logic [NW-1:0] dvs;
  logic          take;

  assign dvs    = NW'(edge_w) << BIT;
  assign take   = in_rem >= dvs;
  assign in_rdy = !out_vld || out_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (in_rdy) begin
      out_vld <= in_vld;
    end
    if (in_rdy) begin
      out_rem    <= take ? in_rem - dvs : in_rem;
      out_quo    <= take ? (in_quo | (QW'(1) << BIT)) : in_quo;
      out_region <= in_region;
    end
  end

endmodule

// ----- sv/sskm_cos_rom.sv -----
// raised-cosine lookup and final weight register
// table built at elaboration from a truncated taylor form; uses sskm_pkg
module sskm_cos_rom #(
  parameter int DEPTH = sskm_pkg::COS_TABLE_DEPTH,
  parameter int QW    = $clog2(DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_vld,
  output logic                           in_rdy,
  input  logic [QW-1:0]                  in_phase,
  input  logic [sskm_pkg::REGION_W-1:0]  in_region,
  output logic                           out_vld,
  input  logic                           out_rdy,
  output logic [sskm_pkg::WEIGHT_W-1:0]  out_weight,
  output logic [sskm_pkg::REGION_W-1:0]  out_region
);

  localparam int HALF = DEPTH / 2;
  localparam int HW   = (HALF + 1 > 1) ? $clog2(HALF + 1) : 1;
  localparam longint unsigned ONE   = 64'd1 << 30;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  function automatic logic [14:0] cos_h(input int q);
    longint unsigned x, x2, t, sub, h;
    x  = (PI_Q30 * longint'(q)) / DEPTH;
    x2 = (x * x) >> 30;
    t  = ONE;
    sub = ((x2 * t) >> 30) / 90;
    t  = (sub >= ONE) ? 64'd0 : ONE - sub;
    sub = ((x2 * t) >> 30) / 56;
    t  = (sub >= ONE) ? 64'd0 : ONE - sub;
    sub = ((x2 * t) >> 30) / 30;
    t  = (sub >= ONE) ? 64'd0 : ONE - sub;
    sub = ((x2 * t) >> 30) / 12;
    t  = (sub >= ONE) ? 64'd0 : ONE - sub;
    sub = ((x2 * t) >> 30) / 2;
    t  = (sub >= ONE) ? 64'd0 : ONE - sub;
    h  = (t + 64'd32768) >> 16;
    if (h > 64'd16384) h = 64'd16384;
    return h[14:0];
  endfunction

  logic [14:0] rom [HALF+1];

  for (genvar i = 0; i <= HALF; i++) begin : g_rom
    assign rom[i] = cos_h(i);
  end

  logic [QW-1:0]                 p_cl;
  logic                          upper;
  logic [QW-1:0]                 q_full;
  logic [14:0]                   h;
  logic                          h_upper;
  logic [sskm_pkg::REGION_W-1:0] h_region;
  logic                          h_vld;
  logic                          h_rdy;
  logic [sskm_pkg::WEIGHT_W-1:0] weight_next;

  assign p_cl   = (in_phase > QW'(DEPTH)) ? QW'(DEPTH) : in_phase;
  assign upper  = {p_cl, 1'b0} > (QW + 1)'(DEPTH);
  assign q_full = upper ? QW'(DEPTH) - p_cl : p_cl;

  assign in_rdy = !h_vld || h_rdy;
  assign h_rdy  = !out_vld || out_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else if (in_rdy) begin
      h_vld <= in_vld;
    end
    if (in_rdy) begin
      h        <= rom[HW'(q_full)];
      h_upper  <= upper;
      h_region <= in_region;
    end
  end

  always_comb begin
    case (h_region) inside
      sskm_pkg::RGN_INNER, sskm_pkg::RGN_OUTER:
        weight_next = h_upper ? sskm_pkg::WEIGHT_HALF - 16'(h)
                              : sskm_pkg::WEIGHT_HALF + 16'(h);
      sskm_pkg::RGN_BODY: weight_next = sskm_pkg::WEIGHT_ONE;
      default:            weight_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (h_rdy) begin
      out_vld <= h_vld;
    end
    if (h_rdy) begin
      out_weight <= weight_next;
      out_region <= h_region;
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// testbench for the soft spherical shell mask top level
// depends on sskm_pkg and soft_shell_mask_voxel_top; predicts each weight in-line
module testbench;

  localparam int LATENCY = 40;
  localparam int STALL_LIMIT = 4000;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [sskm_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [sskm_pkg::WEIGHT_W-1:0] weight;
    logic [sskm_pkg::REGION_W-1:0] region;
  } mask_beat_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [15:0] m_tdata;
  logic [2:0] m_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [sskm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic [15:0] inner_r, outer_r, edge_w;
  mask_beat_t expected_masks[$];
  int errors = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  soft_shell_mask_voxel_top dut (.*);

  initial forever #5 clk = ~clk;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] cos_term(input logic [63:0] x2, t, k);
    logic [63:0] sub;
    sub = ((x2 * t) >> 30) / k;
    return (sub >= Q30_ONE) ? 64'd0 : Q30_ONE - sub;
  endfunction

  function automatic logic [15:0] edge_weight(input logic [63:0] p);
    logic [63:0] q, x, x2, t, h;
    logic upper;
    if (p > sskm_pkg::COS_TABLE_DEPTH) p = sskm_pkg::COS_TABLE_DEPTH;
    upper = (2 * p > sskm_pkg::COS_TABLE_DEPTH);
    q = upper ? sskm_pkg::COS_TABLE_DEPTH - p : p;
    x = (PI_Q30 * q) / sskm_pkg::COS_TABLE_DEPTH;
    x2 = (x * x) >> 30;
    t = cos_term(x2, Q30_ONE, 90);
    t = cos_term(x2, t, 56);
    t = cos_term(x2, t, 30);
    t = cos_term(x2, t, 12);
    t = cos_term(x2, t, 2);
    h = (t + (64'd1 << 15)) >> 16;
    if (h > 16384) h = 16384;
    return upper ? 16'(16384 - h) : 16'(16384 + h);
  endfunction

  function automatic mask_beat_t shell_mask(input logic signed [7:0] x, y, z);
    longint sq, d, inn, out, ew;
    mask_beat_t r;
    sq = longint'(x) * longint'(x) + longint'(y) * longint'(y) + longint'(z) * longint'(z);
    d = longint'(int_sqrt(64'(sq) << 16));
    inn = inner_r;
    out = outer_r;
    ew = (edge_w == 0) ? 1 : edge_w;
    if (d < inn - ew) begin
      r = '{16'd0, sskm_pkg::RGN_HOLE};
    end else if (d < inn) begin
      r = '{edge_weight(64'((inn - d) * sskm_pkg::COS_TABLE_DEPTH / ew)),
            sskm_pkg::RGN_INNER};
    end else if (d < out) begin
      r = '{sskm_pkg::WEIGHT_ONE, sskm_pkg::RGN_BODY};
    end else if (d < out + ew) begin
      r = '{edge_weight(64'((d - out) * sskm_pkg::COS_TABLE_DEPTH / ew)),
            sskm_pkg::RGN_OUTER};
    end else begin
      r = '{16'd0, sskm_pkg::RGN_OUTSIDE};
    end
    return r;
  endfunction

  // valid stays high after the beat so that back-to-back beats need one update
  task automatic send_voxel(input logic [7:0] x, y, z);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {z, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_masks.push_back(shell_mask(x, y, z));
    @(negedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 0;
    while (expected_masks.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_reg(input logic [sskm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      sskm_pkg::REG_INNER: inner_r = val;
      sskm_pkg::REG_OUTER: outer_r = val;
      sskm_pkg::REG_EDGE: edge_w = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_shell(input logic [15:0] inn, out, ew);
    drain();
    write_reg(sskm_pkg::REG_INNER, inn);
    write_reg(sskm_pkg::REG_OUTER, out);
    write_reg(sskm_pkg::REG_EDGE, ew);
    cfg_valid <= 0;
  endtask

  // receiver side and checks
  always @(posedge clk) begin
    mask_beat_t exp_m;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_masks.size() == 0) begin
        $error("unexpected beat: weight %0d region %0d", m_tdata, m_tuser);
        errors++;
      end else begin
        exp_m = expected_masks.pop_front();
        if (m_tdata !== exp_m.weight) begin
          $error("mask_weight: expected %0d actual %0d", exp_m.weight, m_tdata);
          errors++;
        end
        if (m_tuser !== exp_m.region) begin
          $error("region: expected %0d actual %0d", exp_m.region, m_tuser);
          errors++;
        end
      end
    end
  end

  always @(negedge clk)
    m_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_reset_defaults;
    send_voxel(0, 0, 0);
    send_voxel(1, 0, 0);
    send_voxel(8'h80, 8'h80, 8'h80);
  endtask

  task automatic test_extremes;
    set_shell(16'd5120, 16'd12800, 16'd1024);
    send_voxel(0, 0, 0);
    send_voxel(8'h7f, 8'h7f, 8'h7f);
    send_voxel(8'h80, 8'h80, 8'h80);
    send_voxel(8'h80, 0, 0);
    send_voxel(0, 8'h7f, 0);
    send_voxel(0, 0, 8'h80);
    send_voxel(16, 0, 0);
    send_voxel(18, 0, 0);
    send_voxel(25, 0, 0);
    send_voxel(50, 0, 0);
    send_voxel(52, 0, 0);
    send_voxel(8'hce, 0, 0);
    send_voxel(60, 0, 0);
  endtask

  task automatic test_odd_settings;
    set_shell(16'd0, 16'd0, 16'd0);  // zero edge acts as the smallest width
    send_voxel(0, 0, 0);
    send_voxel(1, 1, 1);
    set_shell(16'd12800, 16'd2560, 16'd512);  // inner above outer
    send_voxel(20, 0, 0);
    send_voxel(49, 0, 0);
    send_voxel(11, 0, 0);
    set_shell(16'd256, 16'd2560, 16'd4096);  // inner below edge: no hole
    send_voxel(0, 0, 0);
    send_voxel(20, 0, 0);
    set_shell(16'hffff, 16'hffff, 16'hffff);
    send_voxel(8'h7f, 8'h80, 8'h7f);
    send_voxel(3, 0, 0);
    drain();
    write_reg(REG_NONE, 16'h1234);  // unused index, write dropped
    cfg_valid <= 0;
    send_voxel(1, 2, 3);
  endtask

  task automatic random_phase(input int n);
    logic [15:0] inn, ew;
    int rr;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) begin
        inn = $urandom_range(0, 40 * 256);
        ew = (i % 180 == 0) ? 16'($urandom) : 16'($urandom_range(1, 20 * 256));
        set_shell(inn, 16'(inn + $urandom_range(0, 30 * 256)), ew);
        rr = (inn + $urandom_range(0, 40 * 256)) / 256;
        if (rr > 127) rr = 127;
      end
      if ($urandom_range(3) == 0)
        send_voxel(8'($urandom), 8'($urandom), 8'($urandom));
      else  // keep most voxels near the shell
        send_voxel(8'($urandom_range(0, 2 * rr) - rr), 8'($urandom_range(0, 20) - 10),
                   8'($urandom_range(0, 20) - 10));
    end
  endtask

  initial begin
    inner_r = 0;
    outer_r = 0;
    edge_w = sskm_pkg::EDGE_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_reset_defaults();
    test_extremes();
    test_odd_settings();
    send_idle_pct = 23;
    recv_idle_pct = 58;
    random_phase(360);
    drain();
    send_idle_pct = 58;
    recv_idle_pct = 23;
    random_phase(360);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(380);
    drain();
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
